[src/i2c_register_access_sequencer_assert.svh]
// ----------------------------------------------------------------------------
// i2c register access sequencer assertion macros
// shared property forms for the sequencer checks
// ----------------------------------------------------------------------------
`ifndef I2C_REGISTER_ACCESS_SEQUENCER_ASSERT_SVH
`define I2C_REGISTER_ACCESS_SEQUENCER_ASSERT_SVH

// same-cycle implication, disabled during reset
`define I2CRAS_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("i2cras assertion failed");

// next-cycle implication, disabled during reset
`define I2CRAS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("i2cras assertion failed");

`endif

[src/i2cras_pkg.sv]
// ----------------------------------------------------------------------------
// i2cras_pkg
// shared types and constants of the i2c register access sequencer
// ----------------------------------------------------------------------------
package i2cras_pkg;

   localparam int LENGTH_BITS = 8;

   localparam logic [1:0] OP_EVENT       = 2'd0;
   localparam logic [1:0] OP_START_READ  = 2'd1;
   localparam logic [1:0] OP_START_WRITE = 2'd2;
   localparam logic [1:0] OP_BUS_ERROR   = 2'd3;

   localparam logic [7:0] AUTO_INC_BIT = 8'h80;
   localparam logic [7:0] READ_BIT     = 8'h01;

   localparam logic [LENGTH_BITS-1:0] LEN_ONE = LENGTH_BITS'(1);

   localparam int IRQ_EVENT_BIT  = 0;
   localparam int IRQ_BUFFER_BIT = 1;

   typedef struct packed {
      logic [1:0] op;
      logic [7:0] reg_id;
      logic [7:0] write_value;
      logic [7:0] length;
      logic [7:0] rx_byte;
   } req_type;

   typedef struct packed {
      logic       send_valid;
      logic [7:0] send_byte;
      logic       request_start;
      logic       request_stop;
      logic       ack_enable;
      logic       buffer_irq_enable;
      logic       event_irq_enable;
      logic       rx_valid;
      logic [7:0] rx_data;
      logic       done_res;
      logic       error;
   } rsp_type;

   typedef struct packed {
      logic advance;
      logic drain;
   } step_ctrl_type;

endpackage

[src/i2cras_if.sv]
// ----------------------------------------------------------------------------
// i2cras channel interfaces
// request, response and register write channels with valid/ready
// ----------------------------------------------------------------------------
interface i2cras_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] op;
   logic [7:0] reg_id;
   logic [7:0] write_value;
   logic [7:0] length;
   logic [7:0] rx_byte;

   modport source (output valid, op, reg_id, write_value, length, rx_byte,
                   input ready);
   modport sink   (input valid, op, reg_id, write_value, length, rx_byte,
                   output ready);
endinterface

interface i2cras_rsp_if;
   logic       valid;
   logic       ready;
   logic       send_valid;
   logic [7:0] send_byte;
   logic       request_start;
   logic       request_stop;
   logic       ack_enable;
   logic       buffer_irq_enable;
   logic       event_irq_enable;
   logic       rx_valid;
   logic [7:0] rx_data;
   logic       done_res;
   logic       error;

   modport source (output valid, send_valid, send_byte, request_start, request_stop,
                   ack_enable, buffer_irq_enable, event_irq_enable, rx_valid,
                   rx_data, done_res, error,
                   input ready);
   modport sink   (input valid, send_valid, send_byte, request_start, request_stop,
                   ack_enable, buffer_irq_enable, event_irq_enable, rx_valid,
                   rx_data, done_res, error,
                   output ready);
endinterface

interface i2cras_csr_if;
   logic       valid;
   logic       ready;
   logic [7:0] device_address;

   modport source (output valid, device_address, input ready);
   modport sink   (input valid, device_address, output ready);
endinterface

[src/i2cras_seq.sv]
// ----------------------------------------------------------------------------
// i2cras_seq
// phase state machine and response register of the register sequencer
// ----------------------------------------------------------------------------
`include "i2c_register_access_sequencer_assert.svh"

module i2cras_seq (
   input  logic                     clock,
   input  logic                     reset,
   input  i2cras_pkg::step_ctrl_type ctrl,
   input  i2cras_pkg::req_type       req,
   input  logic [7:0]               dev_addr,
   output logic                     rsp_valid,
   output i2cras_pkg::rsp_type       rsp
);

   typedef enum logic [3:0] {
      PH_IDLE     = 4'd0,
      PH_R_START  = 4'd1,
      PH_R_ADDR   = 4'd2,
      PH_R_REG    = 4'd3,
      PH_R_RSTART = 4'd4,
      PH_R_RADDR  = 4'd5,
      PH_R_MULTI  = 4'd6,
      PH_R_LAST   = 4'd7,
      PH_W_START  = 4'd8,
      PH_W_ADDR   = 4'd9,
      PH_W_REG    = 4'd10,
      PH_W_VAL    = 4'd11
   } phase_type;

   phase_type                          phase_ff, phase_in;
   logic [7:0]                         reg_byte_ff, reg_byte_in;
   logic [7:0]                         value_byte_ff, value_byte_in;
   logic [i2cras_pkg::LENGTH_BITS-1:0] remaining_ff, remaining_in;
   logic                               ack_ff, ack_in;
   logic [1:0]                         irq_ff, irq_in;
   logic                               rsp_valid_ff, rsp_valid_in;
   i2cras_pkg::rsp_type                rsp_ff, rsp_in;

   logic [31:0]                        len_ext;
   logic [i2cras_pkg::LENGTH_BITS-1:0] len_masked;
   logic [i2cras_pkg::LENGTH_BITS-1:0] rem_dec;
   logic                               go_last;

   assign len_ext    = 32'(req.length);
   assign len_masked = len_ext[i2cras_pkg::LENGTH_BITS-1:0];
   assign rem_dec    = remaining_ff - i2cras_pkg::LEN_ONE;

   always_comb begin
      phase_in      = phase_ff;
      reg_byte_in   = reg_byte_ff;
      value_byte_in = value_byte_ff;
      remaining_in  = remaining_ff;
      ack_in        = ack_ff;
      irq_in        = irq_ff;
      rsp_in        = '0;
      go_last       = 1'b0;

      case (req.op)
         i2cras_pkg::OP_START_READ, i2cras_pkg::OP_START_WRITE: begin
            if (phase_ff == PH_IDLE) begin
               reg_byte_in = req.reg_id;
               if (req.op == i2cras_pkg::OP_START_READ) begin
                  remaining_in = len_masked;
                  // auto-increment unless exactly one byte
                  if (len_masked != i2cras_pkg::LEN_ONE) begin
                     reg_byte_in = req.reg_id | i2cras_pkg::AUTO_INC_BIT;
                  end
                  phase_in = PH_R_START;
               end else begin
                  value_byte_in = req.write_value;
                  remaining_in  = i2cras_pkg::LEN_ONE;
                  phase_in      = PH_W_START;
               end
               irq_in                            = '0;
               irq_in[i2cras_pkg::IRQ_EVENT_BIT] = 1'b1;
               ack_in                            = 1'b1;
               rsp_in.request_start              = 1'b1;
            end
         end
         i2cras_pkg::OP_BUS_ERROR: begin
            if (phase_ff != PH_IDLE) begin
               phase_in     = PH_IDLE;
               irq_in       = '0;
               ack_in       = 1'b0;
               rsp_in.error = 1'b1;
            end
         end
         default: begin
            unique case (phase_ff)
               PH_IDLE: begin
               end
               PH_R_START: begin
                  rsp_in.send_valid = 1'b1;
                  rsp_in.send_byte  = dev_addr;
                  phase_in          = PH_R_ADDR;
               end
               PH_R_ADDR: begin
                  rsp_in.send_valid    = 1'b1;
                  rsp_in.send_byte     = reg_byte_ff;
                  rsp_in.request_start = 1'b1;
                  phase_in             = PH_R_REG;
               end
               PH_R_REG: begin
                  phase_in = PH_R_RSTART;
               end
               PH_R_RSTART: begin
                  rsp_in.send_valid = 1'b1;
                  rsp_in.send_byte  = dev_addr | i2cras_pkg::READ_BIT;
                  phase_in          = PH_R_RADDR;
               end
               PH_R_RADDR: begin
                  if (remaining_ff > i2cras_pkg::LEN_ONE) begin
                     phase_in = PH_R_MULTI;
                  end else begin
                     go_last = 1'b1;
                  end
               end
               PH_R_MULTI: begin
                  rsp_in.rx_valid = 1'b1;
                  rsp_in.rx_data  = req.rx_byte;
                  remaining_in    = rem_dec;
                  if (rem_dec <= i2cras_pkg::LEN_ONE) begin
                     go_last = 1'b1;
                  end
               end
               PH_R_LAST: begin
                  rsp_in.rx_valid = 1'b1;
                  rsp_in.rx_data  = req.rx_byte;
                  irq_in          = '0;
                  rsp_in.done_res = 1'b1;
                  phase_in        = PH_IDLE;
               end
               PH_W_START: begin
                  rsp_in.send_valid = 1'b1;
                  rsp_in.send_byte  = dev_addr;
                  phase_in          = PH_W_ADDR;
               end
               PH_W_ADDR: begin
                  rsp_in.send_valid = 1'b1;
                  rsp_in.send_byte  = reg_byte_ff;
                  phase_in          = PH_W_REG;
               end
               PH_W_REG: begin
                  rsp_in.send_valid = 1'b1;
                  rsp_in.send_byte  = value_byte_ff;
                  phase_in          = PH_W_VAL;
               end
               PH_W_VAL: begin
                  irq_in[i2cras_pkg::IRQ_EVENT_BIT] = 1'b0;
                  rsp_in.request_stop               = 1'b1;
                  rsp_in.done_res                   = 1'b1;
                  phase_in                          = PH_IDLE;
               end
               default: begin
                  phase_in = PH_IDLE;
               end
            endcase
         end
      endcase

      // ack dropped and stop requested ahead of the final byte
      if (go_last) begin
         ack_in                             = 1'b0;
         irq_in[i2cras_pkg::IRQ_BUFFER_BIT] = 1'b1;
         rsp_in.request_stop                = 1'b1;
         phase_in                           = PH_R_LAST;
      end

      rsp_in.ack_enable        = ack_in;
      rsp_in.buffer_irq_enable = irq_in[i2cras_pkg::IRQ_BUFFER_BIT];
      rsp_in.event_irq_enable  = irq_in[i2cras_pkg::IRQ_EVENT_BIT];
   end

   always_comb begin
      if (ctrl.advance) begin
         rsp_valid_in = 1'b1;
      end else if (ctrl.drain) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_IDLE;
         reg_byte_ff   <= '0;
         value_byte_ff <= '0;
         remaining_ff  <= '0;
         ack_ff        <= 1'b0;
         irq_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (ctrl.advance) begin
            phase_ff      <= phase_in;
            reg_byte_ff   <= reg_byte_in;
            value_byte_ff <= value_byte_in;
            remaining_ff  <= remaining_in;
            ack_ff        <= ack_in;
            irq_ff        <= irq_in;
         end
      end
      if (ctrl.advance) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

   `I2CRAS_ASSERT_IMPLIES(a_done_idle, clock, reset,
      rsp_valid_ff && rsp_ff.done_res, phase_ff == PH_IDLE)
   `I2CRAS_ASSERT_IMPLIES(a_error_clears, clock, reset,
      rsp_valid_ff && rsp_ff.error, phase_ff == PH_IDLE && !ack_ff && irq_ff == 2'b00)
   `I2CRAS_ASSERT_IMPLIES(a_last_levels, clock, reset,
      phase_ff == PH_R_LAST, !ack_ff && irq_ff[i2cras_pkg::IRQ_BUFFER_BIT])
   `I2CRAS_ASSERT_IMPLIES(a_rstart_with_index, clock, reset,
      rsp_valid_ff && rsp_ff.request_start && rsp_ff.send_valid, phase_ff == PH_R_REG)
   `I2CRAS_ASSERT_NEXT(a_start_leaves_idle, clock, reset,
      ctrl.advance && phase_ff == PH_IDLE &&
      (req.op == i2cras_pkg::OP_START_READ || req.op == i2cras_pkg::OP_START_WRITE),
      phase_ff != PH_IDLE && rsp_valid_ff && rsp_ff.request_start)

endmodule

[src/i2c_register_access_sequencer.sv]
// ----------------------------------------------------------------------------
// i2c_register_access_sequencer
// steps an i2c master through register writes and reads, one request per event
// ----------------------------------------------------------------------------
//   channel   dir   handshake        carries
//   req_ch    in    valid/ready      op, reg_id, write_value, length, rx_byte
//   rsp_ch    out   valid/ready      bus requests, levels, rx byte, done, error
//   csr_ch    in    valid/ready      device_address
//
// an accepted request is held in the input register, then one pass of the phase
// logic writes its result into the response register once that register is free
// one request per cycle sustained while the response is not stalled
// reset is synchronous and clears the phase, levels and the request and response valid flags
// a stalled response holds its register; the input register still takes
// one more request, then req_ch.ready drops until the response moves
// ----------------------------------------------------------------------------
module i2c_register_access_sequencer (
   input logic          clock,
   input logic          reset,
   i2cras_req_if.sink   req_ch,
   i2cras_rsp_if.source rsp_ch,
   i2cras_csr_if.sink   csr_ch
);

   logic                      req_valid_ff, req_valid_in;
   i2cras_pkg::req_type       req_ff;
   logic [7:0]                dev_addr_ff;
   logic                      rsp_valid;
   i2cras_pkg::rsp_type       rsp;
   i2cras_pkg::step_ctrl_type ctrl;

   assign ctrl.advance = req_valid_ff && (!rsp_valid || rsp_ch.ready);
   assign ctrl.drain   = rsp_ch.ready;

   assign req_ch.ready = !req_valid_ff || ctrl.advance;
   assign csr_ch.ready = 1'b1;

   always_comb begin
      if (req_ch.valid && req_ch.ready) begin
         req_valid_in = 1'b1;
      end else if (ctrl.advance) begin
         req_valid_in = 1'b0;
      end else begin
         req_valid_in = req_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         dev_addr_ff  <= '0;
      end else begin
         req_valid_ff <= req_valid_in;
         if (csr_ch.valid && csr_ch.ready) begin
            dev_addr_ff <= csr_ch.device_address;
         end
      end
      if (req_ch.valid && req_ch.ready) begin
         req_ff.op          <= req_ch.op;
         req_ff.reg_id      <= req_ch.reg_id;
         req_ff.write_value <= req_ch.write_value;
         req_ff.length      <= req_ch.length;
         req_ff.rx_byte     <= req_ch.rx_byte;
      end
   end

   i2cras_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (ctrl),
      .req       (req_ff),
      .dev_addr  (dev_addr_ff),
      .rsp_valid (rsp_valid),
      .rsp       (rsp)
   );

   assign rsp_ch.valid             = rsp_valid;
   assign rsp_ch.send_valid        = rsp.send_valid;
   assign rsp_ch.send_byte         = rsp.send_byte;
   assign rsp_ch.request_start     = rsp.request_start;
   assign rsp_ch.request_stop      = rsp.request_stop;
   assign rsp_ch.ack_enable        = rsp.ack_enable;
   assign rsp_ch.buffer_irq_enable = rsp.buffer_irq_enable;
   assign rsp_ch.event_irq_enable  = rsp.event_irq_enable;
   assign rsp_ch.rx_valid          = rsp.rx_valid;
   assign rsp_ch.rx_data           = rsp.rx_data;
   assign rsp_ch.done_res          = rsp.done_res;
   assign rsp_ch.error             = rsp.error;

endmodule
